// File: rtl/aasc_pkg.sv
`default_nettype none

package aasc_pkg;

  localparam int MAX_TARGETS = 64;
  localparam int STATE_BITS  = 16;

  localparam int SYM_W  = 16;
  localparam int TGT_W  = 16;
  localparam int EXP_W  = SYM_W + 1;
  localparam int ADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W  = $clog2(MAX_TARGETS + 1);

  localparam logic [TGT_W-1:0] TGT_MASK = TGT_W'((64'd1 << STATE_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TARGETS);

  // configuration register indexes
  localparam logic REG_SYMBOL_BASE = 1'b0;
  localparam logic REG_SYMBOL_TOP  = 1'b1;

  // item modes
  localparam logic MODE_ENTRY  = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [TGT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// File: rtl/automaton_any_symbol_checker_core.sv
`default_nettype none

// Dot-automaton checker.
// Input channel (in_valid/in_ready): one word per transition destination,
// ordered by state, ascending symbol, ascending destination. mode selects
// an entry word or the finish word that closes the automaton.
// Output channel (out_valid/out_ready): one word (is_dot, overflowed) per
// finish word, shown the cycle after the finish word is taken. Entry words
// give no output.
// Throughput: one word per cycle. The first destination list of each state
// is written into a 64-entry store; later lists read it back one entry per
// word and the read data is compared in the next cycle, folded straight
// into the sticky fail flag, so no word ever waits on the store port.
// The output register holds its word while out_ready is low; input is taken
// whenever that register is empty or draining, so a stalled receiver stops
// the input only when a finish result is still waiting.
// Configuration (cfg_we/cfg_index/cfg_data) sets the symbol range; the
// user must write it only while the block is idle; the block never checks.
// Reset: range back to 0..65535, all check state cleared, output empty. The
// store needs no clearing: only entries written for the current state are
// ever read.

module automaton_any_symbol_checker_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       mode,
  input  wire logic [aasc_pkg::SYM_W-1:0] symbol,
  input  wire logic [aasc_pkg::TGT_W-1:0] target,
  input  wire logic                       end_of_targets,
  input  wire logic                       end_of_symbols,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            is_dot,
  output logic                            overflowed,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [aasc_pkg::SYM_W-1:0] cfg_data
);

  // configuration
  logic [aasc_pkg::SYM_W-1:0] symbol_base;
  logic [aasc_pkg::SYM_W-1:0] symbol_top;

  // check state
  logic                       failed, failed_next;
  logic [aasc_pkg::EXP_W-1:0] expected_symbol, expected_symbol_next;
  logic                       in_range_seen, in_range_seen_next;
  logic                       first_list_done, first_list_done_next;
  logic [aasc_pkg::CNT_W-1:0] reference_count, reference_count_next;
  logic [aasc_pkg::CNT_W-1:0] compare_index, compare_index_next;
  logic                       overflow_flag, overflow_flag_next;
  logic                       mid_list, mid_list_next;

  // compare in flight: store read issued last cycle
  logic                       cmp_pending, cmp_pending_next;
  logic [aasc_pkg::TGT_W-1:0] cmp_target;

  aasc_pkg::ram_req_t         ram_req;
  logic [aasc_pkg::TGT_W-1:0] rd_data;

  logic                       accept;
  logic                       mismatch;
  logic                       in_range;
  logic [aasc_pkg::TGT_W-1:0] tgt;
  logic                       res_is_dot, res_overflowed;

  aasc_ref_ram u_ref_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign mismatch = cmp_pending && (rd_data != cmp_target);
  assign tgt      = target & aasc_pkg::TGT_MASK;
  assign in_range = (symbol >= symbol_base) && (symbol <= symbol_top);

  always_comb begin
    failed_next          = failed | mismatch;
    expected_symbol_next = expected_symbol;
    in_range_seen_next   = in_range_seen;
    first_list_done_next = first_list_done;
    reference_count_next = reference_count;
    compare_index_next   = compare_index;
    overflow_flag_next   = overflow_flag;
    mid_list_next        = mid_list;
    cmp_pending_next     = 1'b0;
    res_is_dot           = 1'b0;
    res_overflowed       = 1'b0;
    ram_req.we           = 1'b0;
    ram_req.waddr        = reference_count[aasc_pkg::ADDR_W-1:0];
    ram_req.wdata        = tgt;
    ram_req.re           = 1'b0;
    ram_req.raddr        = compare_index[aasc_pkg::ADDR_W-1:0];

    if (accept) begin
      if (mode == aasc_pkg::MODE_ENTRY && in_range) begin
        if (!mid_list) begin
          if ({1'b0, symbol} != expected_symbol) begin
            failed_next = 1'b1;
          end
          expected_symbol_next = {1'b0, symbol} + aasc_pkg::EXP_W'(1);
          in_range_seen_next   = 1'b1;
        end
        mid_list_next = 1'b1;
        if (!first_list_done) begin
          if (reference_count < aasc_pkg::CNT_MAX) begin
            ram_req.we           = 1'b1;
            reference_count_next = reference_count + aasc_pkg::CNT_W'(1);
          end else begin
            overflow_flag_next = 1'b1;
            failed_next        = 1'b1;
          end
        end else begin
          // advance on the assumption of a match; a mismatch fails for good
          if (compare_index < reference_count) begin
            ram_req.re         = 1'b1;
            cmp_pending_next   = 1'b1;
            compare_index_next = compare_index + aasc_pkg::CNT_W'(1);
          end else begin
            failed_next = 1'b1;
          end
        end
      end else if (mode == aasc_pkg::MODE_ENTRY) begin
        mid_list_next = 1'b0;
      end

      // close the list on end of targets, end of symbols or finish
      if (mode == aasc_pkg::MODE_FINISH || end_of_symbols || end_of_targets) begin
        if (in_range_seen_next && mid_list_next) begin
          if (first_list_done_next && (compare_index_next != reference_count_next)) begin
            failed_next = 1'b1;
          end
          first_list_done_next = 1'b1;
        end
        compare_index_next = '0;
        mid_list_next      = 1'b0;
      end

      // close the state
      if (mode == aasc_pkg::MODE_FINISH || end_of_symbols) begin
        if (in_range_seen_next &&
            (expected_symbol_next != ({1'b0, symbol_top} + aasc_pkg::EXP_W'(1)))) begin
          failed_next = 1'b1;
        end
        expected_symbol_next = {1'b0, symbol_base};
        in_range_seen_next   = 1'b0;
        first_list_done_next = 1'b0;
        reference_count_next = '0;
        compare_index_next   = '0;
        mid_list_next        = 1'b0;
      end

      if (mode == aasc_pkg::MODE_FINISH) begin
        res_is_dot         = !failed_next;
        res_overflowed     = overflow_flag_next;
        failed_next        = 1'b0;
        overflow_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_base     <= '0;
      symbol_top      <= '1;
      failed          <= 1'b0;
      expected_symbol <= '0;
      in_range_seen   <= 1'b0;
      first_list_done <= 1'b0;
      reference_count <= '0;
      compare_index   <= '0;
      overflow_flag   <= 1'b0;
      mid_list        <= 1'b0;
      cmp_pending     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aasc_pkg::REG_SYMBOL_BASE: symbol_base <= cfg_data;
          aasc_pkg::REG_SYMBOL_TOP:  symbol_top  <= cfg_data;
          default: ;
        endcase
      end
      failed          <= failed_next;
      expected_symbol <= expected_symbol_next;
      in_range_seen   <= in_range_seen_next;
      first_list_done <= first_list_done_next;
      reference_count <= reference_count_next;
      compare_index   <= compare_index_next;
      overflow_flag   <= overflow_flag_next;
      mid_list        <= mid_list_next;
      cmp_pending     <= cmp_pending_next;
      // load a result on finish, drop it once taken
      if (accept && mode == aasc_pkg::MODE_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmp_pending_next) begin
      cmp_target <= tgt;
    end
    if (accept && mode == aasc_pkg::MODE_FINISH) begin
      is_dot     <= res_is_dot;
      overflowed <= res_overflowed;
    end
  end

endmodule

`default_nettype wire

// File: rtl/aasc_ref_ram.sv
`default_nettype none

module aasc_ref_ram (
  input  wire logic                      clk,
  input  wire aasc_pkg::ram_req_t        req,
  output logic [aasc_pkg::TGT_W-1:0]     rd_data
);

  logic [aasc_pkg::TGT_W-1:0] mem [aasc_pkg::MAX_TARGETS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/aasc_checker.sv
`default_nettype none

module aasc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic mode,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic is_dot,
  input wire logic overflowed
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_dot) && $stable(overflowed))
    else $error("output word changed while stalled");

  // a finish word always yields a result next cycle
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == aasc_pkg::MODE_FINISH |=> out_valid)
    else $error("finish word gave no result");

  // an entry word never yields a result
  a_entry_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == aasc_pkg::MODE_ENTRY && (!out_valid || out_ready)
    |=> !out_valid)
    else $error("entry word gave a result");

  // overflow always means a fail
  a_overflow_fails: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |-> !is_dot)
    else $error("overflow reported as pass");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

endmodule

bind automaton_any_symbol_checker_core aasc_checker u_aasc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .mode       (mode),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .is_dot     (is_dot),
  .overflowed (overflowed)
);

`default_nettype wire

// File: dv/dot_verdict_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own model of the
// dot-automaton rule and compares every verdict word against it.
module dot_verdict_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       mode,
  input  logic [aasc_pkg::SYM_W-1:0] symbol,
  input  logic [aasc_pkg::TGT_W-1:0] target,
  input  logic                       end_of_targets,
  input  logic                       end_of_symbols,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       is_dot,
  input  logic                       overflowed,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [aasc_pkg::SYM_W-1:0] cfg_data,
  output int                         failures,
  output int                         verdicts_due
);

  typedef struct packed {
    logic is_dot;
    logic overflowed;
  } verdict_t;

  verdict_t verdict_queue[$];

  logic [aasc_pkg::SYM_W-1:0] range_base;
  logic [aasc_pkg::SYM_W-1:0] range_top;
  logic                       dot_failed;
  logic                       store_overflow;
  logic [aasc_pkg::EXP_W-1:0] next_symbol;
  logic                       saw_in_range;
  logic                       first_list_stored;
  logic                       list_open;
  logic [aasc_pkg::TGT_W-1:0] first_list[aasc_pkg::MAX_TARGETS];
  int                         first_len;
  int                         match_idx;

  function automatic void clear_state();
    next_symbol       = {1'b0, range_base};
    saw_in_range      = 1'b0;
    first_list_stored = 1'b0;
    first_len         = 0;
    match_idx         = 0;
    list_open         = 1'b0;
  endfunction

  // A later list must have matched the whole first list to pass.
  function automatic void close_list();
    if (saw_in_range && list_open) begin
      if (first_list_stored && match_idx != first_len)
        dot_failed = 1'b1;
      first_list_stored = 1'b1;
    end
    match_idx = 0;
    list_open = 1'b0;
  endfunction

  function automatic void close_state();
    close_list();
    if (saw_in_range && next_symbol != {1'b0, range_top} + 17'd1)
      dot_failed = 1'b1;
    clear_state();
  endfunction

  function automatic void take_word();
    verdict_t                   v;
    logic [aasc_pkg::TGT_W-1:0] tgt;
    tgt = target & aasc_pkg::TGT_MASK;
    if (mode == aasc_pkg::MODE_FINISH) begin
      close_state();
      v.is_dot     = ~dot_failed;
      v.overflowed = store_overflow;
      verdict_queue.insert(verdict_queue.size(), v);
      dot_failed     = 1'b0;
      store_overflow = 1'b0;
      clear_state();
    end else begin
      if (symbol >= range_base && symbol <= range_top) begin
        if (!list_open) begin
          if ({1'b0, symbol} != next_symbol)
            dot_failed = 1'b1;
          next_symbol  = {1'b0, symbol} + 17'd1;
          saw_in_range = 1'b1;
        end
        list_open = 1'b1;
        if (!first_list_stored) begin
          if (first_len < aasc_pkg::MAX_TARGETS) begin
            first_list[first_len] = tgt;
            first_len++;
          end else begin
            store_overflow = 1'b1;
            dot_failed     = 1'b1;
          end
        end else if (match_idx < first_len && first_list[match_idx] == tgt) begin
          match_idx++;
        end else begin
          dot_failed = 1'b1;
        end
      end else begin
        list_open = 1'b0;
      end
      if (end_of_symbols)
        close_state();
      else if (end_of_targets)
        close_list();
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      failures       = 0;
      range_base     = '0;
      range_top      = '1;
      dot_failed     = 1'b0;
      store_overflow = 1'b0;
      foreach (first_list[i]) first_list[i] = '0;
      clear_state();
      verdict_queue.delete();
    end else begin
      // compare first: a verdict can never leave on the edge its finish word enters
      if (out_valid && out_ready) begin
        if (verdict_queue.size() == 0) begin
          $error("verdict word with no finish word waiting: is_dot %0b overflowed %0b",
                 is_dot, overflowed);
          failures++;
        end else begin
          want = verdict_queue.pop_front();
          if (is_dot !== want.is_dot) begin
            $error("is_dot: expected %0b, got %0b", want.is_dot, is_dot);
            failures++;
          end
          if (overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed);
            failures++;
          end
        end
      end
      // a word taken on a write edge still sees the old range
      if (in_valid && in_ready)
        take_word();
      if (cfg_we) begin
        case (cfg_index)
          aasc_pkg::REG_SYMBOL_BASE: range_base = cfg_data;
          aasc_pkg::REG_SYMBOL_TOP:  range_top  = cfg_data;
          default: ;
        endcase
      end
    end
    verdicts_due = verdict_queue.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the dot-automaton checker. The checker module
// beside the block does all prediction and comparison; this top only builds
// automata, feeds them in, wiggles both handshakes and calls the result.
module testbench;

  localparam int PHASE_ITEMS = 120;   // words per configuration phase
  localparam int N_PHASES    = 11;
  localparam int HOLD_AT     = 10;    // verdict count at which the receiver stalls
  localparam int HOLD_CYCLES = 400;
  // Longest honest silence is the receiver hold plus a couple of random
  // stall gaps; take that several times over.
  localparam int IDLE_LIMIT  = 2000;

  typedef enum int {
    FLAW_NONE, FLAW_SKIP, FLAW_TARGET, FLAW_SHORT, FLAW_LONG, FLAW_REPEAT, FLAW_STOP
  } flaw_e;

  typedef struct {
    logic                       mode;
    logic [aasc_pkg::SYM_W-1:0] sym;
    logic [aasc_pkg::TGT_W-1:0] tgt;
    logic                       eot;
    logic                       eos;
  } word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       mode = aasc_pkg::MODE_ENTRY;
  logic [aasc_pkg::SYM_W-1:0] symbol = '0;
  logic [aasc_pkg::TGT_W-1:0] target = '0;
  logic                       end_of_targets = 1'b0;
  logic                       end_of_symbols = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       is_dot;
  logic                       overflowed;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = aasc_pkg::REG_SYMBOL_BASE;
  logic [aasc_pkg::SYM_W-1:0] cfg_data = '0;

  int failures;
  int verdicts_due;
  int idle_cycles = 0;
  int words_sent  = 0;

  word_t                      words[$];
  logic [aasc_pkg::TGT_W-1:0] list_proto[$];
  int                         cur_base;
  int                         cur_top;
  bit                         tx_steady;
  bit                         rx_steady;

  // Fixed ranges first: full alphabet, both ends, single symbols, an empty
  // range; the remaining phases draw a random narrow range.
  int fixed_lo[8] = '{0, 0, 65532, 7, 200, 65535, 0, 1000};
  int fixed_hi[8] = '{65535, 3, 65535, 7, 199, 65535, 0, 1004};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  automaton_any_symbol_checker_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .symbol         (symbol),
    .target         (target),
    .end_of_targets (end_of_targets),
    .end_of_symbols (end_of_symbols),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_dot         (is_dot),
    .overflowed     (overflowed),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  dot_verdict_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .symbol         (symbol),
    .target         (target),
    .end_of_targets (end_of_targets),
    .end_of_symbols (end_of_symbols),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_dot         (is_dot),
    .overflowed     (overflowed),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .failures       (failures),
    .verdicts_due   (verdicts_due)
  );

  // Watchdog: reset the count on any accepted word, give up on a long silence.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: draw a stall before every verdict word, sometimes run flat out,
  // and once hold off long enough for a waiting verdict to block the input.
  initial begin
    int gap;
    int taken;
    taken = 0;
    rx_steady = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT)
        gap = HOLD_CYCLES;
      else
        gap = rx_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_word(input word_t w);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // valid stays up with the payload fixed until the block takes it
    in_valid       <= 1'b1;
    mode           <= w.mode;
    symbol         <= w.sym;
    target         <= w.tgt;
    end_of_targets <= w.eot;
    end_of_symbols <= w.eos;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_all();
    foreach (words[i]) send_word(words[i]);
    words.delete();
  endtask

  task automatic push_word(input logic m, input int s, input int t,
                           input logic eot, input logic eos);
    word_t w;
    w.mode = m;
    w.sym  = s[15:0];
    w.tgt  = t[15:0];
    w.eot  = eot;
    w.eos  = eos;
    words.insert(words.size(), w);
  endtask

  task automatic push_finish();
    push_word(aasc_pkg::MODE_FINISH, $urandom, $urandom,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Drain the block and let the last word settle before the next register write.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_range(input int lo, input int hi);
    cur_base = lo;
    cur_top  = hi;
    cfg_we    <= 1'b1;
    cfg_index <= aasc_pkg::REG_SYMBOL_BASE;
    cfg_data  <= lo[15:0];
    @(posedge clk);
    cfg_index <= aasc_pkg::REG_SYMBOL_TOP;
    cfg_data  <= hi[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One destination list for symbol s, taken from the prototype list and
  // bent according to the flaw when this is the flawed symbol.
  task automatic push_list(input int s, input flaw_e flaw, input bit here);
    logic [aasc_pkg::TGT_W-1:0] cur[$];
    int                         j;
    cur = list_proto;
    if (here) begin
      case (flaw)
        FLAW_TARGET: cur[cur.size()-1] = cur[cur.size()-1] ^ (16'd1 << $urandom_range(0, 15));
        FLAW_SHORT:
          if (cur.size() > 1) void'(cur.pop_back());
          else cur.insert(cur.size(), ~cur[0]);
        FLAW_LONG:   cur.insert(cur.size(), 16'($urandom));
        default: ;
      endcase
    end
    for (j = 0; j < cur.size(); j++)
      push_word(aasc_pkg::MODE_ENTRY, s, cur[j], j == cur.size() - 1, 1'b0);
  endtask

  task automatic gen_state(input bit close_it);
    int    len;
    int    span;
    int    at;
    int    i;
    int    n;
    int    r;
    int    start;
    flaw_e flaw;
    start = words.size();
    if (cur_base > cur_top || $urandom_range(0, 9) == 0) begin
      // noise: arbitrary entry words
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        push_word(aasc_pkg::MODE_ENTRY, $urandom, $urandom,
                  1'($urandom_range(0, 1)), 1'b0);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2)       len = $urandom_range(63, 66);   // around the store size
      else if (r < 6)  len = $urandom_range(5, 12);
      else             len = $urandom_range(1, 4);
      list_proto.delete();
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 7);
        list_proto.insert(list_proto.size(),
                          r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : 16'($urandom));
      end
      list_proto.sort();
      flaw = ($urandom_range(0, 2) == 0) ? flaw_e'($urandom_range(1, 6)) : FLAW_NONE;
      span = cur_top - cur_base;
      // a full-width alphabet cannot be walked; cut it short, which fails
      if (span > 7) span = $urandom_range(0, 3);
      at = $urandom_range(0, span);
      if (cur_base > 0 && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 2);
        r = $urandom_range(0, cur_base - 1);
        for (i = 0; i < n; i++)
          push_word(aasc_pkg::MODE_ENTRY, r, $urandom, i == n - 1, 1'b0);
      end
      for (i = 0; i <= span; i++) begin
        if (flaw == FLAW_STOP && i == at) break;
        if (!(flaw == FLAW_SKIP && i == at)) begin
          push_list(cur_base + i, flaw, i == at);
          if (flaw == FLAW_REPEAT && i == at) push_list(cur_base + i, FLAW_NONE, 1'b0);
        end
      end
      if (cur_top < 65535 && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 2);
        r = $urandom_range(cur_top + 1, 65535);
        for (i = 0; i < n; i++)
          push_word(aasc_pkg::MODE_ENTRY, r, $urandom, i == n - 1, 1'b0);
      end
    end
    if (close_it && words.size() > start)
      words[words.size()-1].eos = 1'b1;
  endtask

  task automatic run_automaton();
    int ns;
    int i;
    bit open_end;
    tx_steady = ($urandom_range(0, 3) == 0);
    ns        = $urandom_range(0, 3);
    open_end  = ($urandom_range(0, 4) == 0);
    for (i = 0; i < ns; i++)
      gen_state(!(open_end && i == ns - 1));
    push_finish();
    send_all();
  endtask

  initial begin
    int p;
    int lo;
    int hi;
    int phase_start;
    tx_steady = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: alphabet at the top of the symbol space.
    set_range(65534, 65535);
    push_finish();                                              // empty automaton
    push_word(aasc_pkg::MODE_ENTRY, 0,     7,     1'b1, 1'b0);  // below range, dropped
    push_word(aasc_pkg::MODE_ENTRY, 65534, 0,     1'b0, 1'b0);
    push_word(aasc_pkg::MODE_ENTRY, 65534, 65535, 1'b1, 1'b0);
    push_word(aasc_pkg::MODE_ENTRY, 65535, 0,     1'b0, 1'b0);
    push_word(aasc_pkg::MODE_ENTRY, 65535, 65535, 1'b1, 1'b1);
    push_finish();                                              // clean dot state
    push_word(aasc_pkg::MODE_ENTRY, 65534, 5,     1'b1, 1'b0);
    push_word(aasc_pkg::MODE_ENTRY, 65535, 5,     1'b0, 1'b0);
    push_word(aasc_pkg::MODE_ENTRY, 65535, 6,     1'b1, 1'b1);
    push_finish();                                              // longer second list
    push_word(aasc_pkg::MODE_ENTRY, 65534, 1,     1'b1, 1'b0);
    push_word(aasc_pkg::MODE_ENTRY, 65535, 1,     1'b1, 1'b0);
    push_word(aasc_pkg::MODE_FINISH, 65534, 65535, 1'b1, 1'b1); // finish closes open state
    push_word(aasc_pkg::MODE_ENTRY, 65534, 3,     1'b1, 1'b1);
    push_finish();                                              // top symbol missing
    push_word(aasc_pkg::MODE_ENTRY, 65535, 9,     1'b1, 1'b1);
    push_finish();                                              // base symbol missing
    send_all();
    settle();

    for (p = 0; p < N_PHASES; p++) begin
      if (p < 8) begin
        lo = fixed_lo[p];
        hi = fixed_hi[p];
      end else begin
        lo = ($urandom_range(0, 3) == 0) ? $urandom_range(65530, 65535) : $urandom_range(0, 65535);
        hi = lo + $urandom_range(0, 5);
        if (hi > 65535) hi = 65535;
      end
      set_range(lo, hi);
      // open with a bare finish so the state picks up the new base
      tx_steady = 1'b0;
      push_finish();
      send_all();
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_ITEMS)
        run_automaton();
      settle();
    end

    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/aasc_pkg.sv
rtl/aasc_ref_ram.sv
rtl/automaton_any_symbol_checker_core.sv
rtl/aasc_checker.sv
dv/dot_verdict_checker.sv
dv/testbench.sv
